// File: rtl/gnss_fix_accuracy_check_defines.svh
// ----------------------------------------------------------------------------
// gnss_fix_accuracy_check_defines
// Assertion macros shared by the fix accuracy check.
// The module that uses them provides clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef GNSS_FIX_ACCURACY_CHECK_DEFINES_SVH
`define GNSS_FIX_ACCURACY_CHECK_DEFINES_SVH

// Condition implies property in the same cycle
`define GFAC_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) else $error(msg);

// Condition implies property in the next cycle
`define GFAC_ASSERT_NEXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) else $error(msg);

`endif

// File: rtl/gfac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfac_pkg
// Types and constants of the fix accuracy check.
// ----------------------------------------------------------------------------
package gfac_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned RAD_W  = 64;
	localparam int unsigned ROOT_W = 32;
	localparam int unsigned REM_W  = 35;
	localparam int unsigned T_W    = 35;

	localparam logic [DATA_W-1:0] THRESHOLD_RST = 32'd131072;

	localparam logic FUNC_FIX  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [1:0] COV_UNKNOWN = 2'd0;
	localparam logic [1:0] COV_APPROX  = 2'd1;
	localparam logic [1:0] COV_DIAG    = 2'd2;
	localparam logic [1:0] COV_KNOWN   = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIAG_GO,
		ST_DIAG_WAIT,
		ST_MUL_H,
		ST_MUL_B,
		ST_R_GO,
		ST_R_WAIT,
		ST_T_CALC,
		ST_T_GO,
		ST_T_WAIT
	} gfac_state_t;

	typedef enum logic [1:0] {
		SRC_DIAG,
		SRC_Q,
		SRC_T
	} gfac_src_t;

	typedef struct packed {
		logic      load;
		logic      tick;
		logic      clear_fix;
		logic      mul_h;
		logic      mul_b;
		logic      sqrt_start;
		gfac_src_t src;
		logic      calc_t;
		logic      store;
	} gfac_cmd_t;

	typedef struct packed {
		logic       in_func;
		logic [1:0] in_type;
		logic       sqrt_busy;
		logic       sqrt_done;
	} gfac_sts_t;

endpackage

// File: rtl/gfac_fix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfac_fix_if
// Input channel: fix messages and tick queries.
// ----------------------------------------------------------------------------
interface gfac_fix_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [1:0]         cov_type;
	logic signed [31:0] cov_xx;
	logic signed [31:0] cov_xy;
	logic signed [31:0] cov_yy;

	modport source (
		output valid, func, cov_type, cov_xx, cov_xy, cov_yy,
		input  ready
	);

	modport sink (
		input  valid, func, cov_type, cov_xx, cov_xy, cov_yy,
		output ready
	);
endinterface

// File: rtl/gfac_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfac_res_if
// Result channel: fix status answered for each tick.
// ----------------------------------------------------------------------------
interface gfac_res_if;
	logic        valid;
	logic        ready;
	logic        fix_good;
	logic        accuracy_known;
	logic [31:0] accuracy;

	modport source (
		output valid, fix_good, accuracy_known, accuracy,
		input  ready
	);

	modport sink (
		input  valid, fix_good, accuracy_known, accuracy,
		output ready
	);
endinterface

// File: rtl/gfac_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfac_isqrt
// Radix-2 restoring integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`include "gnss_fix_accuracy_check_defines.svh"

module gfac_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [gfac_pkg::RAD_W-1:0]  radicand,
	output logic                        busy,
	output logic                        done,
	output logic [gfac_pkg::ROOT_W-1:0] root
);

	localparam logic [4:0] STEP_LAST = 5'(gfac_pkg::ROOT_W - 1);

	logic [gfac_pkg::RAD_W-1:0]  rad_q;
	logic [gfac_pkg::REM_W-1:0]  rem_q;
	logic [gfac_pkg::ROOT_W-1:0] root_q;
	logic [4:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [gfac_pkg::REM_W-1:0]  rem_sh;
	logic [gfac_pkg::REM_W-1:0]  trial;
	logic                        fits;

	// bring down the next two radicand bits and try root*4+1
	assign rem_sh = {rem_q[gfac_pkg::REM_W-3:0], rad_q[gfac_pkg::RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[gfac_pkg::RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[gfac_pkg::ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

	`GFAC_ASSERT_NEXT(a_start_busy, start, busy_q, "square root did not start")
	`GFAC_ASSERT_NEXT(a_last_done, busy_q && cnt_q == STEP_LAST && !start, done_q && !busy_q, "square root did not finish after its last step")
	`GFAC_ASSERT_IMP(a_done_idle, done_q, !busy_q, "square root done while still busy")

endmodule

// File: rtl/gfac_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfac_dp
// Datapath: operand capture, shared multiplier, square root unit, fix state
// and the result register.
// ----------------------------------------------------------------------------
module gfac_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gfac_pkg::gfac_cmd_t         cmd,
	output gfac_pkg::gfac_sts_t         sts,
	input  logic                        func,
	input  logic [1:0]                  cov_type,
	input  logic signed [31:0]          cov_xx,
	input  logic signed [31:0]          cov_xy,
	input  logic signed [31:0]          cov_yy,
	input  logic                        cfg_wr_en,
	input  logic [31:0]                 cfg_wr_data,
	output logic                        fix_good,
	output logic                        accuracy_known,
	output logic [31:0]                 accuracy
);

	logic [31:0]                 thr_q;
	logic                        fix_seen_q;
	logic                        acc_valid_q;
	logic [31:0]                 acc_q;

	logic signed [31:0]          a_q;
	logic signed [31:0]          d_q;
	logic [31:0]                 uh_q;
	logic [31:0]                 ub_q;
	logic [63:0]                 prod_q;
	logic [61:0]                 quart_q;
	logic [gfac_pkg::T_W-1:0]    t_q;

	logic                        fix_good_q;
	logic                        known_q;
	logic [31:0]                 acc_out_q;

	logic [32:0]                 h_diff;
	logic [32:0]                 h_mag;
	logic [32:0]                 b_mag;
	logic [31:0]                 mul_op;
	logic [63:0]                 mul_res;
	logic signed [31:0]          m_max;
	logic                        m_pos;
	logic                        t_pos;
	logic [gfac_pkg::RAD_W-1:0]  radicand;
	logic                        sqrt_busy;
	logic                        sqrt_done;
	logic [gfac_pkg::ROOT_W-1:0] root;
	logic                        known;

	// magnitudes taken at capture so the multiplier sees clean operands
	assign h_diff = {cov_xx[31], cov_xx} - {cov_yy[31], cov_yy};
	assign h_mag  = h_diff[32] ? (33'd0 - h_diff) : h_diff;
	assign b_mag  = cov_xy[31] ? (33'd0 - {cov_xy[31], cov_xy}) : {1'b0, cov_xy};

	assign mul_op  = cmd.mul_b ? ub_q : uh_q;
	assign mul_res = mul_op * mul_op;

	assign m_max = (a_q > d_q) ? a_q : d_q;
	assign m_pos = !m_max[31] && (m_max != 32'sd0);
	assign t_pos = !t_q[gfac_pkg::T_W-1] && (t_q != '0);

	always_comb begin
		case (cmd.src)
			gfac_pkg::SRC_DIAG: radicand = m_pos ? {16'd0, m_max, 16'd0} : '0;
			gfac_pkg::SRC_Q:    radicand = {2'b00, quart_q} + prod_q;
			gfac_pkg::SRC_T:    radicand = t_pos ? {15'd0, t_q[gfac_pkg::T_W-2:0], 15'd0} : '0;
			default:            radicand = '0;
		endcase
	end

	gfac_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (radicand),
		.busy     (sqrt_busy),
		.done     (sqrt_done),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= gfac_pkg::THRESHOLD_RST;
			fix_seen_q  <= 1'b0;
			acc_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (cmd.clear_fix) begin
				fix_seen_q  <= 1'b1;
				acc_valid_q <= 1'b0;
				acc_q       <= '0;
			end else if (cmd.store) begin
				fix_seen_q  <= 1'b1;
				acc_valid_q <= 1'b1;
				acc_q       <= root;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q  <= cov_xx;
			d_q  <= cov_yy;
			uh_q <= h_mag[31:0];
			ub_q <= b_mag[31:0];
		end
		if (cmd.mul_h) begin
			prod_q <= mul_res;
		end
		if (cmd.mul_b) begin
			prod_q  <= mul_res;
			quart_q <= prod_q[63:2];
		end
		if (cmd.calc_t) begin
			t_q <= {{3{a_q[31]}}, a_q} + {{3{d_q[31]}}, d_q} + {2'b00, root, 1'b0};
		end
	end

	assign known = fix_seen_q && acc_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			fix_good_q <= known && (acc_q <= thr_q);
			known_q    <= known;
			acc_out_q  <= known ? acc_q : '0;
		end
	end

	assign sts.in_func   = func;
	assign sts.in_type   = cov_type;
	assign sts.sqrt_busy = sqrt_busy;
	assign sts.sqrt_done = sqrt_done;

	assign fix_good       = fix_good_q;
	assign accuracy_known = known_q;
	assign accuracy       = acc_out_q;

endmodule

// File: rtl/gfac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfac_ctrl
// Controller: sequences a fix through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
`include "gnss_fix_accuracy_check_defines.svh"

module gfac_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  gfac_pkg::gfac_sts_t sts,
	output gfac_pkg::gfac_cmd_t cmd
);

	gfac_pkg::gfac_state_t state_q;
	gfac_pkg::gfac_state_t state_d;
	logic                  out_valid_q;
	logic                  accept;
	logic                  tick_acc;

	assign in_ready = (state_q == gfac_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;
	assign tick_acc = accept && (sts.in_func == gfac_pkg::FUNC_TICK);

	always_comb begin
		state_d = state_q;
		case (state_q)
			gfac_pkg::ST_IDLE: begin
				if (accept && sts.in_func == gfac_pkg::FUNC_FIX) begin
					case (sts.in_type)
						gfac_pkg::COV_DIAG:   state_d = gfac_pkg::ST_DIAG_GO;
						gfac_pkg::COV_APPROX: state_d = gfac_pkg::ST_MUL_H;
						gfac_pkg::COV_KNOWN:  state_d = gfac_pkg::ST_MUL_H;
						default:              state_d = gfac_pkg::ST_IDLE;
					endcase
				end
			end
			gfac_pkg::ST_DIAG_GO:   state_d = gfac_pkg::ST_DIAG_WAIT;
			gfac_pkg::ST_DIAG_WAIT: begin
				if (sts.sqrt_done) state_d = gfac_pkg::ST_IDLE;
			end
			gfac_pkg::ST_MUL_H:     state_d = gfac_pkg::ST_MUL_B;
			gfac_pkg::ST_MUL_B:     state_d = gfac_pkg::ST_R_GO;
			gfac_pkg::ST_R_GO:      state_d = gfac_pkg::ST_R_WAIT;
			gfac_pkg::ST_R_WAIT: begin
				if (sts.sqrt_done) state_d = gfac_pkg::ST_T_CALC;
			end
			gfac_pkg::ST_T_CALC:    state_d = gfac_pkg::ST_T_GO;
			gfac_pkg::ST_T_GO:      state_d = gfac_pkg::ST_T_WAIT;
			gfac_pkg::ST_T_WAIT: begin
				if (sts.sqrt_done) state_d = gfac_pkg::ST_IDLE;
			end
			default:                state_d = gfac_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.src = gfac_pkg::SRC_DIAG;
		case (state_q)
			gfac_pkg::ST_IDLE: begin
				if (accept) begin
					if (sts.in_func == gfac_pkg::FUNC_TICK) begin
						cmd.tick = 1'b1;
					end else begin
						cmd.load = 1'b1;
						// unknown type: drop the stored accuracy at once
						cmd.clear_fix = (sts.in_type == gfac_pkg::COV_UNKNOWN);
					end
				end
			end
			gfac_pkg::ST_DIAG_GO: begin
				cmd.sqrt_start = 1'b1;
				cmd.src        = gfac_pkg::SRC_DIAG;
			end
			gfac_pkg::ST_DIAG_WAIT: cmd.store = sts.sqrt_done;
			gfac_pkg::ST_MUL_H:     cmd.mul_h = 1'b1;
			gfac_pkg::ST_MUL_B:     cmd.mul_b = 1'b1;
			gfac_pkg::ST_R_GO: begin
				cmd.sqrt_start = 1'b1;
				cmd.src        = gfac_pkg::SRC_Q;
			end
			gfac_pkg::ST_R_WAIT:    cmd.calc_t = 1'b0;
			gfac_pkg::ST_T_CALC:    cmd.calc_t = 1'b1;
			gfac_pkg::ST_T_GO: begin
				cmd.sqrt_start = 1'b1;
				cmd.src        = gfac_pkg::SRC_T;
			end
			gfac_pkg::ST_T_WAIT:    cmd.store = sts.sqrt_done;
			default:                cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gfac_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// hold the result until it is taken
			if (tick_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`GFAC_ASSERT_NEXT(a_tick_result, tick_acc, out_valid_q, "tick item gave no result")
	`GFAC_ASSERT_IMP(a_busy_waits, sts.sqrt_busy, state_q == gfac_pkg::ST_DIAG_WAIT || state_q == gfac_pkg::ST_R_WAIT || state_q == gfac_pkg::ST_T_WAIT, "square root busy outside a wait state")
	`GFAC_ASSERT_NEXT(a_r_to_t, state_q == gfac_pkg::ST_R_WAIT && sts.sqrt_done, state_q == gfac_pkg::ST_T_CALC, "discriminant root not followed by eigenvalue sum")

endmodule

// File: rtl/gnss_fix_accuracy_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_fix_accuracy_check
// Qualifies a satellite fix by the horizontal accuracy of its covariance.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    func, cov_type, cov_xx, cov_xy, cov_yy
//  rsp      out  valid/ready    fix_good, accuracy_known, accuracy
//  cfg      in   cfg_wr_en      cfg_wr_data (accuracy threshold)
//
// A tick or an unknown-type fix is finished on acceptance. A diagonal fix takes one
// root and a full or approximated fix two (discriminant, then eigenvalue sum), each
// of 32 steps in the square root unit.
// Reset clears the fix state and loads a threshold of 2.0 m.
// One item is in work at a time; any item waits while an untaken result holds
// the result register.
// ----------------------------------------------------------------------------
module gnss_fix_accuracy_check (
	input  logic        clk,
	input  logic        arst_n,
	gfac_fix_if.sink    req,
	gfac_res_if.source  rsp,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	gfac_pkg::gfac_cmd_t cmd;
	gfac_pkg::gfac_sts_t sts;
	logic                in_ready;
	logic                out_valid;

	gfac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gfac_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.func           (req.func),
		.cov_type       (req.cov_type),
		.cov_xx         (req.cov_xx),
		.cov_xy         (req.cov_xy),
		.cov_yy         (req.cov_yy),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.fix_good       (rsp.fix_good),
		.accuracy_known (rsp.accuracy_known),
		.accuracy       (rsp.accuracy)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

endmodule
